>>> src/dsf_pkg.sv
// ----------------------------------------------------------------------------
// Damped spring force package
// Shared widths, register codes, pipeline stage numbers, payload types and
// saturation helpers for the damped spring force block.
// ----------------------------------------------------------------------------
package dsf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LEN_W     = 32;
    localparam int QW        = FRAC_BITS + 1;
    localparam int UW        = FRAC_BITS + 2;
    localparam int PW        = 32 + UW;
    localparam int WW        = 80;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REST     = 2'd3;

    localparam logic signed [31:0] GAIN_RESET = 32'(100 << FRAC_BITS);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int STG_SQ    = 0;
    localparam int STG_SUM   = 1;
    localparam int STG_RT0   = 2;
    localparam int STG_DINIT = STG_RT0 + LEN_W;
    localparam int STG_DV0   = STG_DINIT + 1;
    localparam int STG_UNIT  = STG_DV0 + QW;
    localparam int STG_PDV   = STG_UNIT + 1;
    localparam int STG_PROJ  = STG_PDV + 1;
    localparam int STG_KP    = STG_PROJ + 1;
    localparam int STG_SCL   = STG_KP + 1;
    localparam int STG_MP    = STG_SCL + 1;
    localparam int STG_FIN   = STG_MP + 1;
    localparam int NSTG      = STG_FIN + 1;

    localparam logic signed [WW-1:0] W_MAX = WW'(64'sd2147483647);
    localparam logic signed [WW-1:0] W_MIN = ~W_MAX;

    typedef struct packed {
        logic signed [31:0] end1_pos_x;
        logic signed [31:0] end1_pos_y;
        logic signed [31:0] end1_pos_z;
        logic signed [31:0] end2_pos_x;
        logic signed [31:0] end2_pos_y;
        logic signed [31:0] end2_pos_z;
        logic signed [31:0] end1_vel_x;
        logic signed [31:0] end1_vel_y;
        logic signed [31:0] end1_vel_z;
        logic signed [31:0] end2_vel_x;
        logic signed [31:0] end2_vel_y;
        logic signed [31:0] end2_vel_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               force_applied;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] stretch;
        logic signed [31:0] compress;
        logic signed [31:0] damp;
        logic [30:0]        rest;
    } cfg_t;

    typedef struct {
        logic signed [31:0] d [3];
        logic signed [31:0] dv [3];
        logic               sat_d;
        logic               sat_v;
    } fq_t;

    typedef struct {
        logic signed [31:0]   d [3];
        logic signed [31:0]   dv [3];
        logic                 sat;
        logic                 sat_v;
        logic [62:0]          sq [3];
        logic [63:0]          rem;
        logic [LEN_W-1:0]     root;
        logic [32:0]          drem [3];
        logic [QW-1:0]        q [3];
        logic signed [UW-1:0] u [3];
        logic signed [31:0]   e;
        logic                 stretched;
        logic signed [PW-1:0] pdv [3];
        logic signed [63:0]   ee;
        logic signed [31:0]   proj;
        logic [30:0]          sqc;
        logic signed [63:0]   kp;
        logic signed [63:0]   mg;
        logic signed [31:0]   s;
        logic signed [31:0]   mag;
        logic signed [PW-1:0] sp [3];
        logic signed [PW-1:0] mp [3];
        out_item_t            res;
    } bk_t;

    function automatic logic ovf32(input logic signed [WW-1:0] x);
        return (x > W_MAX) || (x < W_MIN);
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [WW-1:0] x);
        logic signed [31:0] r;
        if (x > W_MAX)
        begin
            r = 32'sh7fffffff;
        end
        else if (x < W_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = $signed(x[31:0]);
        end
        return r;
    endfunction

endpackage

>>> src/dsf_ifs.sv
// ----------------------------------------------------------------------------
// Damped spring force channels
// Valid/ready channels for input beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface dsf_in_if import dsf_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dsf_out_if import dsf_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dsf_cfg_if import dsf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/dsf_front.sv
// ----------------------------------------------------------------------------
// Damped spring force front end
// Accepts input beats, forms the clamped position and velocity differences
// and hands them to the queue.
// ----------------------------------------------------------------------------
module dsf_front import dsf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    dsf_in_if.sink      item,
    output fq_t         push_data,
    output logic        push_valid,
    input  logic        push_ready
);

    fq_t  stage_reg;
    fq_t  stage_next;
    logic vld_reg;
    logic vld_next;
    logic accept;

    assign item.ready = !vld_reg || push_ready;
    assign accept     = item.valid && item.ready;
    assign push_valid = vld_reg;
    assign push_data  = stage_reg;

    always_comb
    begin
        logic signed [31:0] p1 [3];
        logic signed [31:0] p2 [3];
        logic signed [31:0] v1 [3];
        logic signed [31:0] v2 [3];
        logic signed [WW-1:0] t;
        p1[0] = item.data.end1_pos_x;
        p1[1] = item.data.end1_pos_y;
        p1[2] = item.data.end1_pos_z;
        p2[0] = item.data.end2_pos_x;
        p2[1] = item.data.end2_pos_y;
        p2[2] = item.data.end2_pos_z;
        v1[0] = item.data.end1_vel_x;
        v1[1] = item.data.end1_vel_y;
        v1[2] = item.data.end1_vel_z;
        v2[0] = item.data.end2_vel_x;
        v2[1] = item.data.end2_vel_y;
        v2[2] = item.data.end2_vel_z;
        stage_next.sat_d = 1'b0;
        stage_next.sat_v = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            t = WW'(p2[i]) - WW'(p1[i]);
            stage_next.d[i] = clip32(t);
            stage_next.sat_d = stage_next.sat_d | ovf32(t);
            t = WW'(v2[i]) - WW'(v1[i]);
            stage_next.dv[i] = clip32(t);
            stage_next.sat_v = stage_next.sat_v | ovf32(t);
        end
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (push_ready)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

>>> src/dsf_queue.sv
// ----------------------------------------------------------------------------
// Damped spring force queue
// Short first-in first-out buffer between the front end and the pipeline.
// ----------------------------------------------------------------------------
module dsf_queue import dsf_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  fq_t  push_data,
    input  logic push_valid,
    output logic push_ready,
    output fq_t  head,
    output logic head_valid,
    input  logic pop
);

    fq_t            slot_reg [QDEPTH];
    logic [QAW-1:0] wr_reg;
    logic [QAW-1:0] wr_next;
    logic [QAW-1:0] rd_reg;
    logic [QAW-1:0] rd_next;
    logic [QAW:0]   cnt_reg;
    logic [QAW:0]   cnt_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = cnt_reg != (QAW+1)'(QDEPTH);
    assign head_valid = cnt_reg != '0;
    assign head       = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

>>> src/dsf_back.sv
// ----------------------------------------------------------------------------
// Damped spring force pipeline
// Square root, unit vector division, damping and spring force stages, ending
// in the result register.
// ----------------------------------------------------------------------------
module dsf_back import dsf_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  fq_t    head,
    input  logic   head_valid,
    output logic   pop,
    dsf_out_if.source result
);

    bk_t             pipe_reg [NSTG];
    bk_t             pipe_next [NSTG];
    logic [NSTG-1:0] vld_reg;
    logic            en;

    function automatic bk_t bk_step(input int k, input bk_t x, input cfg_t c);
        bk_t                y;
        logic [63:0]        trial;
        logic [32:0]        dr;
        logic [31:0]        m;
        logic signed [WW-1:0] w;
        logic signed [WW-1:0] acc;
        logic signed [31:0] fo [3];
        logic               fsat;
        logic               kd_on;
        logic signed [31:0] gain;
        logic signed [63:0] p64;
        int                 j;
        y     = x;
        kd_on = c.damp > 0;
        gain  = x.stretched ? c.stretch : c.compress;
        if (k == STG_SQ)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p64      = x.d[i] * x.d[i];
                y.sq[i]  = p64[62:0];
            end
        end
        else if (k == STG_SUM)
        begin
            y.rem  = 64'(x.sq[0]) + 64'(x.sq[1]) + 64'(x.sq[2]);
            y.root = '0;
        end
        else if (k >= STG_RT0 && k < STG_DINIT)
        begin
            j     = LEN_W - 1 - (k - STG_RT0);
            trial = (64'(x.root) << (j + 1)) + (64'd1 << (2 * j));
            if (x.rem >= trial)
            begin
                y.rem  = x.rem - trial;
                y.root = x.root | (LEN_W'(1) << j);
            end
        end
        else if (k == STG_DINIT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m         = x.d[i][31] ? ~x.d[i] + 32'd1 : x.d[i];
                y.drem[i] = {1'b0, m};
                y.q[i]    = '0;
            end
        end
        else if (k >= STG_DV0 && k < STG_UNIT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dr = (k == STG_DV0) ? x.drem[i] : {x.drem[i][31:0], 1'b0};
                if (dr >= {1'b0, x.root})
                begin
                    y.drem[i] = dr - {1'b0, x.root};
                    y.q[i]    = {x.q[i][QW-2:0], 1'b1};
                end
                else
                begin
                    y.drem[i] = dr;
                    y.q[i]    = {x.q[i][QW-2:0], 1'b0};
                end
            end
        end
        else if (k == STG_UNIT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (x.root == '0)
                begin
                    y.u[i] = '0;
                end
                else if (x.d[i][31])
                begin
                    y.u[i] = -$signed({1'b0, x.q[i]});
                end
                else
                begin
                    y.u[i] = $signed({1'b0, x.q[i]});
                end
            end
            w           = WW'($signed({1'b0, x.root})) - WW'($signed({1'b0, c.rest}));
            y.e         = clip32(w);
            y.sat       = x.sat | ovf32(w);
            y.stretched = x.root > {1'b0, c.rest};
        end
        else if (k == STG_PDV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                y.pdv[i] = x.dv[i] * x.u[i];
            end
            y.ee = x.e * x.e;
        end
        else if (k == STG_PROJ)
        begin
            acc    = WW'(x.pdv[0]) + WW'(x.pdv[1]) + WW'(x.pdv[2]);
            w      = acc >>> FRAC_BITS;
            y.proj = clip32(w);
            y.sat  = x.sat | (kd_on && (x.sat_v || ovf32(w)));
            w      = WW'(x.ee >>> FRAC_BITS);
            y.sqc  = ovf32(w) ? 31'h7fffffff : w[30:0];
            y.sat  = y.sat | ovf32(w);
        end
        else if (k == STG_KP)
        begin
            y.kp = c.damp * x.proj;
            y.mg = $signed({1'b0, x.sqc}) * gain;
        end
        else if (k == STG_SCL)
        begin
            w     = WW'(x.kp >>> FRAC_BITS);
            y.s   = clip32(w);
            y.sat = x.sat | (kd_on && ovf32(w));
            w     = WW'(x.mg >>> FRAC_BITS);
            y.mag = clip32(w);
            y.sat = y.sat | ovf32(w);
        end
        else if (k == STG_MP)
        begin
            for (int i = 0; i < 3; i++)
            begin
                y.sp[i] = x.s * x.u[i];
                y.mp[i] = x.mag * x.u[i];
            end
        end
        else if (k == STG_FIN)
        begin
            fsat = x.sat;
            for (int i = 0; i < 3; i++)
            begin
                w = WW'(x.mp[i] >>> FRAC_BITS);
                if (kd_on)
                begin
                    w = w - WW'(x.sp[i] >>> FRAC_BITS);
                end
                if (!x.stretched)
                begin
                    w = -w;
                end
                fo[i] = clip32(w);
                fsat  = fsat | ovf32(w);
            end
            if (gain <= 0)
            begin
                y.res = '0;
            end
            else
            begin
                y.res.force_x       = fo[0];
                y.res.force_y       = fo[1];
                y.res.force_z       = fo[2];
                y.res.force_applied = 1'b1;
                y.res.saturated     = fsat;
            end
        end
        return y;
    endfunction

    assign en            = !vld_reg[NSTG-1] || result.ready;
    assign pop           = en && head_valid;
    assign result.valid  = vld_reg[NSTG-1];
    assign result.data   = pipe_reg[NSTG-1].res;

    always_comb
    begin
        bk_t first;
        first       = '{default: '0};
        first.d     = head.d;
        first.dv    = head.dv;
        first.sat   = head.sat_d;
        first.sat_v = head.sat_v;
        pipe_next[0] = bk_step(0, first, cfg);
        for (int k = 1; k < NSTG; k++)
        begin
            pipe_next[k] = bk_step(k, pipe_reg[k-1], cfg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], head_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

endmodule

>>> src/damped_spring_force_top.sv
// ----------------------------------------------------------------------------
// Damped spring force unit
// Computes the damped spring force on end one of a spring from the positions
// and velocities of both ends, in signed fixed point with saturation.
//
// Channels: item carries one beat per spring (positions and velocities),
// result returns one beat per item (force vector and flags), and cfg writes
// the four gain and length registers; cfg is always ready.
// A new item is taken every cycle while the receiver keeps up. The pipeline
// holds the 32-stage square root and the FRAC_BITS + 1 stage divider that
// forms the unit direction.
// When the receiver stalls, the whole pipeline holds; the four-entry queue
// and the front register keep taking beats until they are full.
// Reset clears all valid state and loads the register defaults: both spring
// gains 100.0, damping 0, rest length 0.
// ----------------------------------------------------------------------------
module damped_spring_force_top import dsf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    dsf_in_if.sink    item,
    dsf_out_if.source result,
    dsf_cfg_if.sink   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    fq_t  push_data;
    logic push_valid;
    logic push_ready;
    fq_t  head;
    logic head_valid;
    logic pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_STRETCH:  cfg_next.stretch  = $signed(cfg.data);
                REG_COMPRESS: cfg_next.compress = $signed(cfg.data);
                REG_DAMP:     cfg_next.damp     = $signed(cfg.data);
                REG_REST:     cfg_next.rest     = cfg.data[30:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stretch  <= GAIN_RESET;
            cfg_reg.compress <= GAIN_RESET;
            cfg_reg.damp     <= '0;
            cfg_reg.rest     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dsf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    dsf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    dsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .result     (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pipeline popped an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && !push_ready |=> push_valid)
        else $error("front end dropped a beat while the queue was full");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.data.force_applied |->
            result.data.force_x == '0 && result.data.force_y == '0 &&
            result.data.force_z == '0 && !result.data.saturated)
        else $error("force not applied but result fields are nonzero");

endmodule

>>> test/tb_damped_spring_force_top.sv
// ----------------------------------------------------------------------------
// Damped spring force testbench
// Drives spring beats through the item channel with bursty gaps, stalls the
// result channel on its own pattern, predicts every force beat in fixed point
// and compares each result beat field by field, over several register sets.
// ----------------------------------------------------------------------------
module tb_damped_spring_force_top;
    import dsf_pkg::*;

    logic clk;
    logic rst_n;

    dsf_in_if  item ();
    dsf_out_if result ();
    dsf_cfg_if cfg ();

    damped_spring_force_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;

    in_item_t  pending_q [$];
    out_item_t force_q [$];

    logic signed [31:0] k_stretch;
    logic signed [31:0] k_compress;
    logic signed [31:0] k_damp;
    logic [30:0]        rest_len;

    int  errors;
    int  gap_left;
    int  burst_left;
    int  hold_cycles;
    bit  pause_send;
    bit  took_beat;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint sat_to(input longint x, input longint lo, input longint hi,
                                      inout bit flag);
        if (x < lo)
        begin
            flag = 1'b1;
            return lo;
        end
        if (x > hi)
        begin
            flag = 1'b1;
            return hi;
        end
        return x;
    endfunction

    function automatic longint fshift(input longint x);
        return x >>> FRAC_BITS;
    endfunction

    function automatic longint root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic out_item_t spring_force(input in_item_t it);
        out_item_t o;
        bit sat;
        longint p1 [3], p2 [3], v1 [3], v2 [3];
        longint d [3], u [3], dmp [3], f [3];
        longint unsigned ss;
        longint len, gain, e, sq, mag, acc, proj, s, dv, q;
        longint unsigned m;
        bit stretched;
        sat = 1'b0;
        p1 = '{it.end1_pos_x, it.end1_pos_y, it.end1_pos_z};
        p2 = '{it.end2_pos_x, it.end2_pos_y, it.end2_pos_z};
        v1 = '{it.end1_vel_x, it.end1_vel_y, it.end1_vel_z};
        v2 = '{it.end2_vel_x, it.end2_vel_y, it.end2_vel_z};
        ss = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = sat_to(p2[i] - p1[i], S_MIN, S_MAX, sat);
            ss = ss + longint'(d[i] * d[i]);
        end
        len = root_floor(ss);
        for (int i = 0; i < 3; i++)
        begin
            if (len == 0)
            begin
                u[i] = 0;
            end
            else
            begin
                m = (d[i] < 0) ? -d[i] : d[i];
                q = longint'((m << FRAC_BITS) / longint'(len));
                u[i] = (d[i] < 0) ? -q : q;
            end
            dmp[i] = 0;
        end
        if (k_damp > 0)
        begin
            acc = 0;
            for (int i = 0; i < 3; i++)
            begin
                dv = sat_to(v2[i] - v1[i], S_MIN, S_MAX, sat);
                acc = acc + dv * u[i];
            end
            proj = sat_to(fshift(acc), S_MIN, S_MAX, sat);
            s = sat_to(fshift(longint'(k_damp) * proj), S_MIN, S_MAX, sat);
            for (int i = 0; i < 3; i++)
                dmp[i] = fshift(s * u[i]);
        end
        stretched = len > longint'(rest_len);
        gain = stretched ? longint'(k_stretch) : longint'(k_compress);
        o = '0;
        if (gain <= 0)
            return o;
        e = sat_to(len - longint'(rest_len), S_MIN, S_MAX, sat);
        sq = sat_to(fshift(e * e), 0, S_MAX, sat);
        mag = sat_to(fshift(sq * gain), S_MIN, S_MAX, sat);
        for (int i = 0; i < 3; i++)
        begin
            f[i] = fshift(mag * u[i]) - dmp[i];
            if (!stretched)
                f[i] = -f[i];
            f[i] = sat_to(f[i], S_MIN, S_MAX, sat);
        end
        o.force_x = f[0][31:0];
        o.force_y = f[1][31:0];
        o.force_z = f[2][31:0];
        o.force_applied = 1'b1;
        o.saturated = sat;
        return o;
    endfunction

    // Driver: bursts of beats with random gaps, held while the sender pauses.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item.valid <= 1'b0;
        end
        else
        begin
            if (took_beat)
                void'(pending_q.pop_front());
            if (item.valid && !took_beat)
            begin
                item.valid <= 1'b1;
            end
            else if (pause_send || pending_q.size() == 0)
            begin
                item.valid <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                item.valid <= 1'b0;
            end
            else
            begin
                item.valid <= 1'b1;
                item.data <= pending_q[0];
                if (burst_left > 0)
                begin
                    burst_left <= burst_left - 1;
                end
                else
                begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Prediction on acceptance; registers only change while the block is idle.
    always @(posedge clk)
    begin
        took_beat <= rst_n && item.valid && item.ready;
        if (rst_n && item.valid && item.ready)
            force_q.push_back(spring_force(item.data));
    end

    // Receiver stall pattern, with one long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            result.ready <= 1'b0;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: result.ready <= ($urandom_range(0, 1) == 1);
                1: result.ready <= ($urandom_range(0, 4) != 0);
                default: result.ready <= 1'b1;
            endcase
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        out_item_t exp_f;
        if (rst_n && result.valid && result.ready)
        begin
            if (force_q.size() == 0)
            begin
                $display("%0t unexpected result beat: %p", $time, result.data);
                errors++;
            end
            else
            begin
                exp_f = force_q.pop_front();
                if (result.data.force_x !== exp_f.force_x)
                begin
                    $display("%0t force_x expected %0d actual %0d", $time,
                             exp_f.force_x, result.data.force_x);
                    errors++;
                end
                if (result.data.force_y !== exp_f.force_y)
                begin
                    $display("%0t force_y expected %0d actual %0d", $time,
                             exp_f.force_y, result.data.force_y);
                    errors++;
                end
                if (result.data.force_z !== exp_f.force_z)
                begin
                    $display("%0t force_z expected %0d actual %0d", $time,
                             exp_f.force_z, result.data.force_z);
                    errors++;
                end
                if (result.data.force_applied !== exp_f.force_applied)
                begin
                    $display("%0t force_applied expected %0b actual %0b", $time,
                             exp_f.force_applied, result.data.force_applied);
                    errors++;
                end
                if (result.data.saturated !== exp_f.saturated)
                begin
                    $display("%0t saturated expected %0b actual %0b", $time,
                             exp_f.saturated, result.data.saturated);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_STRETCH:  k_stretch = val;
            REG_COMPRESS: k_compress = val;
            REG_DAMP:     k_damp = val;
            default:      rest_len = val[30:0];
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || item.valid || force_q.size() != 0)
            @(posedge clk);
        repeat (70)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord(input int mode);
        case (mode)
            0: return $signed($urandom());
            1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            default: return $signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000;
        endcase
    endfunction

    function automatic in_item_t rand_spring();
        in_item_t it;
        int mode;
        logic signed [31:0] base;
        mode = $urandom_range(0, 4);
        if (mode > 2)
            mode = 1;
        it.end1_pos_x = rand_coord(mode);
        it.end1_pos_y = rand_coord(mode);
        it.end1_pos_z = rand_coord(mode);
        it.end2_pos_x = rand_coord(mode);
        it.end2_pos_y = rand_coord(mode);
        it.end2_pos_z = rand_coord(mode);
        it.end1_vel_x = rand_coord($urandom_range(0, 2));
        it.end1_vel_y = rand_coord($urandom_range(0, 2));
        it.end1_vel_z = rand_coord($urandom_range(0, 2));
        it.end2_vel_x = rand_coord($urandom_range(0, 2));
        it.end2_vel_y = rand_coord($urandom_range(0, 2));
        it.end2_vel_z = rand_coord($urandom_range(0, 2));
        if ($urandom_range(0, 15) == 0)
        begin
            base = $signed($urandom());
            it.end2_pos_x = it.end1_pos_x;
            it.end2_pos_y = it.end1_pos_y;
            it.end2_pos_z = it.end1_pos_z;
            it.end1_vel_x = base;
        end
        return it;
    endfunction

    task automatic directed_beats();
        in_item_t it;
        logic signed [31:0] ext [4];
        ext = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh00010000};
        for (int i = 0; i < 16; i++)
        begin
            it = '0;
            it.end1_pos_x = ext[i % 4];
            it.end2_pos_x = ext[(i / 4) % 4];
            it.end1_pos_y = ext[(i + 1) % 4];
            it.end2_pos_y = ext[(i + 3) % 4];
            it.end2_pos_z = ext[(i + 2) % 4];
            it.end1_vel_x = ext[(i / 4) % 4];
            it.end2_vel_x = ext[i % 4];
            it.end2_vel_y = ext[(i + 1) % 4];
            it.end1_vel_z = ext[(i + 2) % 4];
            pending_q.push_back(it);
        end
        pending_q.push_back('0);
        it = '1;
        pending_q.push_back(it);
        it = '0;
        it.end2_pos_x = 32'sh00020000;
        it.end2_vel_x = 32'sh00050000;
        pending_q.push_back(it);
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
            pending_q.push_back(rand_spring());
    endtask

    initial
    begin
        errors = 0;
        gap_left = 0;
        burst_left = 0;
        hold_cycles = 0;
        pause_send = 1'b0;
        took_beat = 1'b0;
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.data = '0;
        result.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_STRETCH;
        cfg.data = '0;
        k_stretch = GAIN_RESET;
        k_compress = GAIN_RESET;
        k_damp = '0;
        rest_len = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_beats();
        random_phase(150);
        repeat (20)
            @(posedge clk);
        hold_cycles = 300;
        wait_drained();

        write_reg(REG_DAMP, 32'h00010000);
        write_reg(REG_REST, 32'h00030000);
        directed_beats();
        random_phase(250);
        wait_drained();

        write_reg(REG_STRETCH, 32'h7fffffff);
        write_reg(REG_COMPRESS, 32'h80000000);
        write_reg(REG_DAMP, 32'h7fffffff);
        write_reg(REG_REST, 32'h7fffffff);
        random_phase(200);
        wait_drained();

        write_reg(REG_STRETCH, 32'h0);
        write_reg(REG_COMPRESS, 32'h00000001);
        write_reg(REG_DAMP, 32'h80000000);
        write_reg(REG_REST, 32'h0);
        directed_beats();
        random_phase(200);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_STRETCH, $urandom_range(0, 7) == 0 ? $urandom() :
                      $urandom_range(1, 32'h00ffffff));
            write_reg(REG_COMPRESS, $urandom_range(0, 7) == 0 ? $urandom() :
                      $urandom_range(1, 32'h00ffffff));
            write_reg(REG_DAMP, $urandom_range(0, 3) == 0 ? $urandom() :
                      $urandom_range(1, 32'h0003ffff));
            write_reg(REG_REST, $urandom_range(0, 3) == 0 ? $urandom() :
                      $urandom_range(0, 32'h01ffffff));
            random_phase(150);
            if (ph == 1)
            begin
                while (pending_q.size() > 75)
                    @(posedge clk);
                @(negedge clk);
                pause_send = 1'b1;
                @(posedge clk);
                while (item.valid)
                    @(posedge clk);
                while (force_q.size() != 0)
                    @(posedge clk);
                @(negedge clk);
                pause_send = 1'b0;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
